// File: design/ilha_pkg.sv
// ----------------------------------------------------------------------------
// ilha_pkg - shared definitions for the implicit list heap allocator
// Heap geometry, field widths, command and status codes, sequencer states
// and the structs that pass between the sequencer, the adder and the store.
// ----------------------------------------------------------------------------
package ilha_pkg;

  // Heap geometry
  localparam int HEAP_BYTES = 4096;
  localparam int HDR_BYTES  = 8;
  localparam int SPLIT_MIN  = 16;
  localparam int GRANULES   = HEAP_BYTES / HDR_BYTES;
  localparam int GW         = $clog2(GRANULES);
  localparam int GLO        = $clog2(HDR_BYTES);
  localparam int HDR_W      = $clog2(HEAP_BYTES) + 1;

  // Transfer field widths
  localparam int CMD_W   = 1;
  localparam int REQ_W   = 13;
  localparam int POFF_W  = 12;
  localparam int GRANT_W = 12;
  localparam int STAT_W  = 1;

  // Width of positions and sums inside the sequencer
  localparam int WIDE_W = ((HDR_W > REQ_W) ? HDR_W : REQ_W) + 2;

  localparam logic [HDR_W-1:0] END_MARK = HDR_W'(1);

  localparam logic [CMD_W-1:0]  CMD_ALLOC = 1'b0;
  localparam logic [CMD_W-1:0]  CMD_FREE  = 1'b1;
  localparam logic [STAT_W-1:0] ST_OK     = 1'b0;
  localparam logic [STAT_W-1:0] ST_FAIL   = 1'b1;

  typedef enum logic [3:0] {
    S_INIT0,
    S_INIT1,
    S_IDLE,
    S_A_WALK,
    S_A_FIT,
    S_A_KEEP,
    S_A_REST,
    S_A_TAILW,
    S_A_GRANT,
    S_F_WALK,
    S_F_NEXT,
    S_F_PRED,
    S_F_MERGE,
    S_DONE
  } ilha_state_t;

  typedef struct packed {
    logic [WIDE_W-1:0] a;
    logic [WIDE_W-1:0] b;
    logic              sub;
  } alu_op_t;

  typedef struct packed {
    logic              we;
    logic [WIDE_W-1:0] waddr;
    logic [HDR_W-1:0]  wdata;
    logic [WIDE_W-1:0] raddr;
  } mem_req_t;

  // Block size held in a header word: drop the allocated bit
  function automatic logic [WIDE_W-1:0] hdr_size(input logic [HDR_W-1:0] v);
    return WIDE_W'({v[HDR_W-1:1], 1'b0});
  endfunction

endpackage

// File: design/ilha_in_if.sv
// ----------------------------------------------------------------------------
// ilha_in_if - command channel
// Valid/ready channel carrying one allocate or free command per transfer.
// ----------------------------------------------------------------------------
interface ilha_in_if;
  import ilha_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [REQ_W-1:0]  request_size;
  logic [POFF_W-1:0] payload_offset;

  modport source (output valid, command, request_size, payload_offset, input ready);
  modport sink   (input valid, command, request_size, payload_offset, output ready);
endinterface

// File: design/ilha_out_if.sv
// ----------------------------------------------------------------------------
// ilha_out_if - result channel
// Valid/ready channel carrying one result per command.
// ----------------------------------------------------------------------------
interface ilha_out_if;
  import ilha_pkg::*;

  logic               valid;
  logic               ready;
  logic [GRANT_W-1:0] granted_offset;
  logic [STAT_W-1:0]  status;

  modport source (output valid, granted_offset, status, input ready);
  modport sink   (input valid, granted_offset, status, output ready);
endinterface

// File: design/ilha_alu.sv
// ----------------------------------------------------------------------------
// ilha_alu - shared adder
// The single add/subtract unit that the sequencer steps borrow.
// ----------------------------------------------------------------------------
module ilha_alu (
  input  ilha_pkg::alu_op_t            op,
  output logic [ilha_pkg::WIDE_W-1:0]  sum
);
  import ilha_pkg::*;

  assign sum = op.a + (op.sub ? ~op.b : op.b) + WIDE_W'(op.sub);

endmodule

// File: design/ilha_hdr_store.sv
// ----------------------------------------------------------------------------
// ilha_hdr_store - header word memory
// One header word per granule; one write and one registered read a cycle.
// Reads beyond the heap return the end marker, writes beyond it are dropped.
// ----------------------------------------------------------------------------
module ilha_hdr_store (
  input  logic                         clk,
  input  ilha_pkg::mem_req_t           req,
  output logic [ilha_pkg::HDR_W-1:0]   rdata
);
  import ilha_pkg::*;

  logic [HDR_W-1:0] mem [GRANULES];
  logic [HDR_W-1:0] rd_r;
  logic             oob_r;

  always_ff @(posedge clk) begin
    if (req.we && (req.waddr < WIDE_W'(HEAP_BYTES))) begin
      mem[req.waddr[GW+GLO-1:GLO]] <= req.wdata;
    end
    rd_r  <= mem[req.raddr[GW+GLO-1:GLO]];
    oob_r <= (req.raddr >= WIDE_W'(HEAP_BYTES));
  end

  assign rdata = oob_r ? END_MARK : rd_r;

endmodule

// File: design/ilha_seq.sv
// ----------------------------------------------------------------------------
// ilha_seq - allocator sequencer
// Walks the header list one word a cycle, drives the shared adder and the
// header store, and holds the result register of the output channel.
// ----------------------------------------------------------------------------
module ilha_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ilha_pkg::CMD_W-1:0]    in_command,
  input  logic [ilha_pkg::REQ_W-1:0]    in_request_size,
  input  logic [ilha_pkg::POFF_W-1:0]   in_payload_offset,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ilha_pkg::GRANT_W-1:0]  out_granted_offset,
  output logic [ilha_pkg::STAT_W-1:0]   out_status,
  output ilha_pkg::alu_op_t             alu_op,
  input  logic [ilha_pkg::WIDE_W-1:0]   alu_sum,
  output ilha_pkg::mem_req_t            mem_req,
  input  logic [ilha_pkg::HDR_W-1:0]    rdata
);
  import ilha_pkg::*;

  ilha_state_t state_r, state_nxt;

  logic [WIDE_W-1:0]  pos_r,   pos_nxt;
  logic [WIDE_W-1:0]  h_r,     h_nxt;
  logic [WIDE_W-1:0]  req8_r,  req8_nxt;
  logic [HDR_W-1:0]   s_r,     s_nxt;
  logic [WIDE_W-1:0]  keep_r,  keep_nxt;
  logic [HDR_W-1:0]   sz_r,    sz_nxt;
  logic [WIDE_W-1:0]  prev_r,  prev_nxt;
  logic [HDR_W-1:0]   vprev_r, vprev_nxt;
  logic               first_r, first_nxt;
  logic [GRANT_W-1:0] grant_r, grant_nxt;
  logic [STAT_W-1:0]  stat_r,  stat_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [GRANT_W-1:0] ogrant_r, ogrant_nxt;
  logic [STAT_W-1:0]  ostat_r,  ostat_nxt;

  logic [WIDE_W-1:0]  size_w;
  logic [WIDE_W-1:0]  keep_w;

  assign size_w = hdr_size(rdata);
  assign keep_w = alu_sum & ~WIDE_W'(HDR_BYTES - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT0;
      first_r  <= 1'b1;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      first_r  <= first_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    h_r      <= h_nxt;
    req8_r   <= req8_nxt;
    s_r      <= s_nxt;
    keep_r   <= keep_nxt;
    sz_r     <= sz_nxt;
    prev_r   <= prev_nxt;
    vprev_r  <= vprev_nxt;
    grant_r  <= grant_nxt;
    stat_r   <= stat_nxt;
    ogrant_r <= ogrant_nxt;
    ostat_r  <= ostat_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    h_nxt      = h_r;
    req8_nxt   = req8_r;
    s_nxt      = s_r;
    keep_nxt   = keep_r;
    sz_nxt     = sz_r;
    prev_nxt   = prev_r;
    vprev_nxt  = vprev_r;
    first_nxt  = first_r;
    grant_nxt  = grant_r;
    stat_nxt   = stat_r;
    ovalid_nxt = ovalid_r && !out_ready;
    ogrant_nxt = ogrant_r;
    ostat_nxt  = ostat_r;
    in_ready   = 1'b0;
    alu_op     = '{a: '0, b: '0, sub: 1'b0};
    mem_req    = '{we: 1'b0, waddr: '0, wdata: '0, raddr: '0};

    unique case (state_r)
      S_INIT0: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = HDR_W'(HEAP_BYTES - HDR_BYTES);
        state_nxt     = S_INIT1;
      end
      S_INIT1: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = WIDE_W'(HEAP_BYTES - HDR_BYTES);
        mem_req.wdata = END_MARK;
        state_nxt     = S_IDLE;
      end
      S_IDLE: begin
        in_ready     = 1'b1;
        alu_op.a     = (in_command == CMD_ALLOC) ? WIDE_W'(in_request_size)
                                                 : WIDE_W'(in_payload_offset);
        alu_op.b     = WIDE_W'(HDR_BYTES);
        alu_op.sub   = (in_command == CMD_FREE);
        if (in_valid) begin
          pos_nxt   = '0;
          first_nxt = 1'b1;
          grant_nxt = '0;
          stat_nxt  = ST_FAIL;
          if (in_command == CMD_ALLOC) begin
            req8_nxt  = alu_sum;
            state_nxt = (in_request_size == '0) ? S_DONE : S_A_WALK;
          end else begin
            h_nxt     = alu_sum;
            state_nxt = (WIDE_W'(in_payload_offset) < WIDE_W'(HDR_BYTES)) ? S_DONE
                                                                           : S_F_WALK;
          end
        end
      end
      S_A_WALK: begin
        alu_op.a = pos_r;
        alu_op.b = size_w;
        if (!rdata[0] && (WIDE_W'(rdata) >= req8_r)) begin
          s_nxt     = rdata;
          state_nxt = S_A_FIT;
        end else if ((rdata == END_MARK) || (size_w == '0)) begin
          state_nxt = S_DONE;
        end else begin
          pos_nxt       = alu_sum;
          mem_req.raddr = alu_sum;
        end
      end
      S_A_FIT: begin
        // split when the leftover keeps room for a minimum block
        alu_op.a = req8_r;
        alu_op.b = WIDE_W'(SPLIT_MIN - 1);
        if (WIDE_W'(s_r) >= alu_sum) begin
          state_nxt = S_A_KEEP;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_r;
          mem_req.wdata = s_r | HDR_W'(1);
          state_nxt     = S_A_GRANT;
        end
      end
      S_A_KEEP: begin
        alu_op.a      = req8_r;
        alu_op.b      = WIDE_W'(HDR_BYTES - 1);
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_r;
        mem_req.wdata = keep_w[HDR_W-1:0] | HDR_W'(1);
        keep_nxt      = keep_w;
        state_nxt     = S_A_REST;
      end
      S_A_REST: begin
        alu_op.a   = WIDE_W'(s_r);
        alu_op.b   = keep_r;
        alu_op.sub = 1'b1;
        sz_nxt     = alu_sum[HDR_W-1:0];
        state_nxt  = S_A_TAILW;
      end
      S_A_TAILW: begin
        alu_op.a      = pos_r;
        alu_op.b      = keep_r;
        mem_req.we    = 1'b1;
        mem_req.waddr = alu_sum;
        mem_req.wdata = sz_r;
        state_nxt     = S_A_GRANT;
      end
      S_A_GRANT: begin
        alu_op.a  = pos_r;
        alu_op.b  = WIDE_W'(HDR_BYTES);
        grant_nxt = alu_sum[GRANT_W-1:0];
        stat_nxt  = ST_OK;
        state_nxt = S_DONE;
      end
      S_F_WALK: begin
        alu_op.a = pos_r;
        alu_op.b = size_w;
        if (pos_r == h_r) begin
          if ((rdata == END_MARK) || !rdata[0]) begin
            state_nxt = S_DONE;
          end else begin
            sz_nxt        = size_w[HDR_W-1:0];
            mem_req.raddr = alu_sum;
            state_nxt     = S_F_NEXT;
          end
        end else if ((rdata == END_MARK) || (size_w == '0) || (pos_r > h_r)) begin
          state_nxt = S_DONE;
        end else begin
          pos_nxt       = alu_sum;
          mem_req.raddr = alu_sum;
        end
      end
      S_F_NEXT: begin
        // absorb the following block when it is free
        alu_op.a      = WIDE_W'(sz_r);
        alu_op.b      = rdata[0] ? '0 : WIDE_W'(rdata);
        mem_req.we    = 1'b1;
        mem_req.waddr = h_r;
        mem_req.wdata = alu_sum[HDR_W-1:0];
        sz_nxt        = alu_sum[HDR_W-1:0];
        if (h_r == '0) begin
          stat_nxt  = ST_OK;
          state_nxt = S_DONE;
        end else begin
          pos_nxt   = '0;
          first_nxt = 1'b1;
          state_nxt = S_F_PRED;
        end
      end
      S_F_PRED: begin
        // hunt for the block in front of the freed one
        alu_op.a = pos_r;
        alu_op.b = size_w;
        if (!first_r && (rdata == END_MARK)) begin
          state_nxt = S_F_MERGE;
        end else if ((alu_sum == h_r) || (alu_sum == pos_r)) begin
          prev_nxt  = pos_r;
          vprev_nxt = rdata;
          state_nxt = S_F_MERGE;
        end else begin
          prev_nxt      = pos_r;
          vprev_nxt     = rdata;
          pos_nxt       = alu_sum;
          mem_req.raddr = alu_sum;
          first_nxt     = 1'b0;
        end
      end
      S_F_MERGE: begin
        alu_op.a = WIDE_W'(vprev_r);
        alu_op.b = WIDE_W'(sz_r);
        stat_nxt = ST_OK;
        if (!vprev_r[0]) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = prev_r;
          mem_req.wdata = alu_sum[HDR_W-1:0];
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_r || out_ready) begin
          ovalid_nxt = 1'b1;
          ogrant_nxt = grant_r;
          ostat_nxt  = stat_r;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid          = ovalid_r;
  assign out_granted_offset = ogrant_r;
  assign out_status         = ostat_r;

endmodule

// File: design/implicit_list_heap_allocator_top.sv
// ----------------------------------------------------------------------------
// implicit_list_heap_allocator_top - first-fit heap allocator
// Implicit header list, first-fit allocate with splitting, free with merging.
// ----------------------------------------------------------------------------
// Each command transfer is worked on alone: the sequencer reads one header
// word per cycle from a header memory with one read and one write port, so a
// command's run time grows with the number of headers it walks. An allocate
// walks headers from the start of the heap to the first fit, then splits the
// block where the leftover allows and reports; a free walks up to its own
// header, absorbs the following block when free, then walks up to its
// predecessor and merges into it when free, so at worst it walks the heap of
// 512 granules twice. The single read port is what limits the walk. After
// reset, the block writes the initial free block and end marker and takes no
// command meanwhile. A finished result sits in an output register, so the
// next command is taken while the previous result waits.
// ----------------------------------------------------------------------------
module implicit_list_heap_allocator_top (
  input  logic         clk,
  input  logic         rst_n,
  ilha_in_if.sink      in_chan,
  ilha_out_if.source   out_chan
);
  import ilha_pkg::*;

  alu_op_t           alu_op;
  logic [WIDE_W-1:0] alu_sum;
  mem_req_t          mem_req;
  logic [HDR_W-1:0]  rdata;

  // Shared adder: position advance, size sums, compare thresholds
  ilha_alu u_alu (
    .op  (alu_op),
    .sum (alu_sum)
  );

  // Header words, one per 8-byte granule
  ilha_hdr_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  // Sequencer: walk, split, merge, and hold the result register
  ilha_seq u_seq (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_chan.valid),
    .in_ready           (in_chan.ready),
    .in_command         (in_chan.command),
    .in_request_size    (in_chan.request_size),
    .in_payload_offset  (in_chan.payload_offset),
    .out_valid          (out_chan.valid),
    .out_ready          (out_chan.ready),
    .out_granted_offset (out_chan.granted_offset),
    .out_status         (out_chan.status),
    .alu_op             (alu_op),
    .alu_sum            (alu_sum),
    .mem_req            (mem_req),
    .rdata              (rdata)
  );

  // A failing command always reports a zero offset
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.status == ST_FAIL)) |-> (out_chan.granted_offset == '0))
    else $error("failed result carries a non-zero offset");

  // Granted offsets sit on a granule boundary
  a_grant_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.granted_offset[GLO-1:0] == '0))
    else $error("granted offset not granule aligned");

  // The header store is never written while the block waits for a command
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !mem_req.we)
    else $error("header write while idle");

  // The result register holds while its transfer is stalled
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ready) |=>
      (out_chan.valid && $stable(out_chan.granted_offset) && $stable(out_chan.status)))
    else $error("result changed while stalled");

endmodule
